// File: src/vwma_pkg.sv
// Shared constants, state encoding and control structs for the moving-average core.
`default_nettype none

package vwma_pkg;

    // Store depth and sample width
    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 32;

    // Fixed field widths of the ports
    localparam int WL_BITS   = 6;
    localparam int USED_BITS = 6;

    // Reset value of the window length register
    localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(5);

    // Derived widths
    localparam int PTR_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
    localparam int CMP_BITS     = (CNT_BITS > WL_BITS) ? CNT_BITS : WL_BITS;
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DVD_BITS     = SUM_BITS + 1;
    localparam int DSR_BITS     = CNT_BITS + 1;
    localparam int REM_BITS     = CNT_BITS + 2;
    localparam int DIV_STEPS    = DVD_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DROP_RD,
        S_DROP_SUB,
        S_APPEND,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_sample;
        logic rd_oldest;
        logic drop;
        logic append;
        logic div_start;
        logic load_out;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic drop_needed;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

// File: src/vwma_if.sv
// Handshake channel interfaces for sample input, result output and configuration.
`default_nettype none

interface vwma_in_if import vwma_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface vwma_out_if import vwma_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic        [USED_BITS-1:0]   samples_used;

    modport source (output valid, output average, output samples_used, input ready);
    modport sink   (input valid, input average, input samples_used, output ready);
endinterface

interface vwma_cfg_if import vwma_pkg::*;;
    logic               valid;
    logic               ready;
    logic [WL_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// File: src/variable_window_moving_average_core.sv
// Top level of the variable-window moving-average core.
// Each request runs through check, then a read and a subtract per sample dropped, then
// append, divide prepare and the serial divide before the result is loaded.
// One item at a time: the 38-step serial divider stays busy until the result is ready.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) empties the window, clears the sum and sets window to 5.
`default_nettype none

module variable_window_moving_average_core import vwma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vwma_in_if.sink    i_in,
    vwma_out_if.source o_out,
    vwma_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    vwma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    vwma_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg.valid && i_cfg.ready),
        .i_cfg_wl       (i_cfg.window_length),
        .i_sample       (i_in.sample),
        .o_average      (o_out.average),
        .o_samples_used (o_out.samples_used)
    );

endmodule

`default_nettype wire

// File: src/vwma_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module vwma_div import vwma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_BITS-1:0] i_dividend,
    input  logic [DSR_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [DVD_BITS-1:0] o_quotient
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0]     r_dvd;
    logic [REM_BITS-1:0]     r_rem;
    logic [DSR_BITS-1:0]     r_dsr;

    logic [REM_BITS-1:0] rem_shift;
    logic [REM_BITS-1:0] rem_next;
    logic                fit;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_shift = {r_rem[REM_BITS-2:0], r_dvd[DVD_BITS-1]};
        fit       = (rem_shift >= REM_BITS'(r_dsr));
        rem_next  = fit ? (rem_shift - REM_BITS'(r_dsr)) : rem_shift;
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend register fills with quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], fit};
            r_rem <= rem_next;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

// File: src/vwma_datapath.sv
// Sample store, running sum, window register, divider and output register.
`default_nettype none

module vwma_datapath import vwma_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_cfg_we,
    input  logic        [WL_BITS-1:0]     i_cfg_wl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic        [USED_BITS-1:0]   o_samples_used
);

    logic        [WL_BITS-1:0]     r_wl;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic        [CNT_BITS-1:0]    r_count;
    logic        [PTR_BITS-1:0]    r_oldest;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic                          r_neg;
    logic signed [SAMPLE_BITS-1:0] r_average;
    logic        [USED_BITS-1:0]   r_used;

    logic [CMP_BITS-1:0]    wl_ext;
    logic [CMP_BITS-1:0]    win;
    logic [PTR_BITS:0]      slot_sum;
    logic [PTR_BITS-1:0]    slot;
    logic [PTR_BITS-1:0]    oldest_next;
    logic                   sum_neg;
    logic [SUM_BITS-1:0]    mag;
    logic [DVD_BITS-1:0]    dividend;
    logic [DSR_BITS-1:0]    divisor;
    logic                   div_done;
    logic [DVD_BITS-1:0]    quotient;
    logic [SAMPLE_BITS-1:0] q_low;

    // Clamp the window to one..MAX_WINDOW
    always_comb begin
        wl_ext = CMP_BITS'(r_wl);
        if (wl_ext == '0) begin
            win = CMP_BITS'(1);
        end else if (wl_ext > CMP_BITS'(MAX_WINDOW)) begin
            win = CMP_BITS'(MAX_WINDOW);
        end else begin
            win = wl_ext;
        end
    end

    // Write slot and pointer advance, wrapping at the store depth
    always_comb begin
        slot_sum = {1'b0, r_oldest} + (PTR_BITS + 1)'(r_count);
        if (slot_sum >= (PTR_BITS + 1)'(MAX_WINDOW)) begin
            slot = PTR_BITS'(slot_sum - (PTR_BITS + 1)'(MAX_WINDOW));
        end else begin
            slot = PTR_BITS'(slot_sum);
        end
        if (r_oldest == PTR_BITS'(MAX_WINDOW - 1)) begin
            oldest_next = '0;
        end else begin
            oldest_next = r_oldest + 1'b1;
        end
    end

    // Rounded-division operands: (2|sum| + n) / 2n
    always_comb begin
        sum_neg  = r_sum[SUM_BITS-1];
        mag      = sum_neg ? SUM_BITS'(-r_sum) : SUM_BITS'(r_sum);
        dividend = {mag, 1'b0} + DVD_BITS'(r_count);
        divisor  = {r_count, 1'b0};
    end

    assign o_status.drop_needed = (CMP_BITS'(r_count) >= win);
    assign o_status.div_done    = div_done;

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= WL_RESET;
        end else if (i_cfg_we) begin
            r_wl <= i_cfg_wl;
        end
    end

    // Sample store: write on append, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[slot] <= r_sample;
        end
        if (i_cmd.rd_oldest) begin
            r_rd_data <= r_mem[r_oldest];
        end
    end

    // Window bookkeeping: drop the oldest or append the new sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else if (i_cmd.drop) begin
            r_sum    <= r_sum - SUM_BITS'(r_rd_data);
            r_oldest <= oldest_next;
            r_count  <= r_count - 1'b1;
        end else if (i_cmd.append) begin
            r_sum   <= r_sum + SUM_BITS'(r_sample);
            r_count <= r_count + 1'b1;
        end
    end

    // Capture the request sample, the sign, and the result
    assign q_low = quotient[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.div_start) begin
            r_neg <= sum_neg;
        end
        if (i_cmd.load_out) begin
            r_average <= r_neg ? $signed(-q_low) : $signed(q_low);
            r_used    <= USED_BITS'(r_count);
        end
    end

    vwma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_average      = r_average;
    assign o_samples_used = r_used;

endmodule

`default_nettype wire

// File: src/vwma_ctrl.sv
// Controller state machine: request intake, window trimming, divide, result handoff.
`default_nettype none

module vwma_ctrl import vwma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.drop_needed ? S_DROP_RD : S_APPEND;
            end
            S_DROP_RD:  n_state = S_DROP_SUB;
            S_DROP_SUB: n_state = S_CHECK;
            S_APPEND:   n_state = S_PREP;
            S_PREP:     n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            S_DROP_RD:  o_cmd.rd_oldest = 1'b1;
            S_DROP_SUB: o_cmd.drop      = 1'b1;
            S_APPEND:   o_cmd.append    = 1'b1;
            S_PREP:     o_cmd.div_start = 1'b1;
            S_DONE:     o_cmd.load_out  = out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Set output valid on load, clear when the result is taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/vwma_checker.sv
// Port-level assertions for the moving-average core, bound to the top level.
`default_nettype none

module vwma_checker import vwma_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_average,
    input logic [USED_BITS-1:0]   i_samples_used
);

    // Sample count of a result lies in one..MAX_WINDOW
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_samples_used != '0) && (i_samples_used <= MAX_WINDOW))
        else $error("samples_used out of range");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_average)
                                           && $stable(i_samples_used)))
        else $error("stalled result changed");

    // Drop ready after a request is taken: the block works on one item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after accept");

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind variable_window_moving_average_core vwma_checker u_vwma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_average      (o_out.average),
    .i_samples_used (o_out.samples_used)
);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the variable-window moving-average core.
`timescale 1ns / 100ps

module tb;
    import vwma_pkg::*;

    // Directed part and random part sizes
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int TAIL_CYCLES   = 120;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WINDOW
    } t_row_kind;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] average;
        logic        [USED_BITS-1:0]   samples_used;
    } t_mean;

    typedef struct {
        t_row_kind                     kind;
        logic        [SAMPLE_BITS-1:0] value;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] avg;
        logic        [USED_BITS-1:0]   used;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vwma_in_if  in_ch ();
    vwma_out_if out_ch ();
    vwma_cfg_if cfg_ch ();

    variable_window_moving_average_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: window contents, fill level, oldest slot, exact sum, register
    logic signed [SAMPLE_BITS-1:0] win_store [MAX_WINDOW];
    int unsigned                   win_count  = 0;
    int unsigned                   win_oldest = 0;
    longint                        win_sum    = 0;
    logic        [WL_BITS-1:0]     win_len    = WL_RESET;

    t_mean pending_means [$];
    t_mean want;
    int    mismatches = 0;
    bit    idle_on    = 1'b1;

    // Directed stimulus; expected values only where they are obvious
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 6'd1},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 6'd2},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_WINDOW, 32'd0,         1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 32'h1234_5678, 6'd1},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000, 6'd1},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 6'd1},
        '{ROW_WINDOW, 32'd2,         1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h0000_0002, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFE, 1'b0, 32'h0, 6'd0},
        '{ROW_WINDOW, 32'd63,        1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0, 6'd0},
        '{ROW_WINDOW, 32'd3,         1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_WINDOW, 32'd32,        1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 32'h0, 6'd0},
        '{ROW_WINDOW, 32'd1,         1'b0, 32'h0, 6'd0},
        '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 32'h5555_5555, 6'd1}
    };

    // Drop old samples, append the new one, return the rounded mean
    function automatic t_mean advance_window(input logic signed [SAMPLE_BITS-1:0] s);
        int unsigned     eff;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned n;
        bit              neg;
        t_mean           r;
        eff = win_len;
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > MAX_WINDOW) begin
            eff = MAX_WINDOW;
        end
        while (win_count >= eff && win_count > 0) begin
            win_sum    -= win_store[win_oldest];
            win_oldest  = (win_oldest + 1) % MAX_WINDOW;
            win_count--;
        end
        win_store[(win_oldest + win_count) % MAX_WINDOW] = s;
        win_sum += s;
        win_count++;
        n   = win_count;
        neg = (win_sum < 0);
        mag = neg ? -win_sum : win_sum;
        // Round half away from zero on the magnitude, then restore the sign
        q = (2 * mag + n) / (2 * n);
        if (neg) begin
            q = -q;
        end
        r.average      = q[SAMPLE_BITS-1:0];
        r.samples_used = n[USED_BITS-1:0];
        return r;
    endfunction

    // Offer one sample request, after a random gap when idling is on, and record its expected mean
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit typed,
                               input t_mean typed_mean);
        int    gap;
        t_mean pred;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = advance_window(s);
        pending_means.insert(pending_means.size(), typed ? typed_mean : pred);
    endtask

    // Hold off new requests until every pending mean has come out
    task automatic wait_means_done();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_means.size() != 0);
    endtask

    // Write the window length register while the core is idle
    task automatic write_window(input logic [WL_BITS-1:0] wl);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= wl;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        win_len = wl;
    endtask

    // Stall the result channel for a random gap before each result when idling is on
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Compare each accepted result with the oldest pending mean
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_means.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result: avg %0d used %0d",
                             out_ch.average, out_ch.samples_used);
                end
                mismatches++;
            end else begin
                want = pending_means.pop_front();
                if (out_ch.average !== want.average ||
                    out_ch.samples_used !== want.samples_used) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch: expected avg %0d used %0d, got avg %0d used %0d",
                                 want.average, want.samples_used,
                                 out_ch.average, out_ch.samples_used);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int                            sent;
        int                            phase_len;
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] s;
        logic        [WL_BITS-1:0]     wl;
        t_mean                         typed_mean;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            win_store[i] = '0;
        end
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.sample         <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.window_length <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_WINDOW) begin
                wait_means_done();
                write_window(directed_rows[i].value[WL_BITS-1:0]);
            end else begin
                typed_mean.average      = directed_rows[i].avg;
                typed_mean.samples_used = directed_rows[i].used;
                send_sample(directed_rows[i].value, directed_rows[i].typed, typed_mean);
            end
        end

        // Random phases, each with its own window setting and idling mode
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_means_done();
            pick = $urandom_range(0, 9);
            case (pick)
                0: wl = '0;
                1: wl = WL_BITS'(1);
                2: wl = WL_BITS'(MAX_WINDOW);
                3: wl = WL_BITS'($urandom_range(MAX_WINDOW + 1, 63));
                default: wl = WL_BITS'($urandom_range(1, MAX_WINDOW));
            endcase
            write_window(wl);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(8, 60);
            repeat (phase_len) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0: s = 32'sh7FFF_FFFF;
                    1: s = 32'sh8000_0000;
                    2: s = int'($urandom_range(0, 8)) - 4;
                    default: s = $urandom;
                endcase
                if ($urandom_range(0, 39) == 0) begin
                    wait_means_done();
                end
                send_sample(s, 1'b0, typed_mean);
                sent++;
            end
        end

        wait_means_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
src/vwma_pkg.sv
src/vwma_if.sv
src/vwma_div.sv
src/vwma_datapath.sv
src/vwma_ctrl.sv
src/variable_window_moving_average_core.sv
src/vwma_checker.sv
dv/tb.sv
